FILE: sv/level_pi_controller_top_macros.svh
// assertion helpers shared by the level controller modules
`ifndef LEVEL_PI_CONTROLLER_TOP_MACROS_SVH
`define LEVEL_PI_CONTROLLER_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define LPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lpc_pkg.sv
package lpc_pkg;

  // sample and voltage scaling
  localparam int ADC_BITS   = 8;
  localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
  localparam int FULL_SCALE = 40960;
  localparam int HALF_SCALE = 20480;
  localparam int OUT_MAX    = 10485760;
  localparam int LEVEL_MAX  = 99;

  // field and operand widths
  localparam int VOLT_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 17;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CFG_W   = 24;

  // reciprocals of five: 19-bit operand with shift 22, 11-bit operand with shift 15
  localparam int RECIP5_WIDE  = 838861;
  localparam int RECIP5_NARROW = 6554;

  // input action codes
  localparam logic ACT_ADC  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    CFG_GAIN_PROP      = 3'd0,
    CFG_GAIN_PREV      = 3'd1,
    CFG_KNOB_LOW_VOLT  = 3'd2,
    CFG_KNOB_MID_VOLT  = 3'd3,
    CFG_KNOB_HIGH_VOLT = 3'd4,
    CFG_MID_LEVEL_CM   = 3'd5,
    CFG_SLOPE_ABOVE    = 3'd6,
    CFG_SLOPE_BELOW    = 3'd7
  } lpc_cfg_idx_e;

  // register reset values
  localparam logic signed [23:0] RST_GAIN_PROP = 24'sd2304164;
  localparam logic signed [23:0] RST_GAIN_PREV = -24'sd2303836;
  localparam logic [15:0] RST_KNOB_LOW  = 16'd1475;
  localparam logic [15:0] RST_KNOB_MID  = 16'd3441;
  localparam logic [15:0] RST_KNOB_HIGH = 16'd8602;
  localparam logic [14:0] RST_MID_CM    = 15'd4352;
  localparam logic [15:0] RST_SLOPE_AB  = 16'd3251;
  localparam logic [15:0] RST_SLOPE_BE  = 16'd7467;

  typedef struct packed {
    logic signed [23:0] gain_prop;
    logic signed [23:0] gain_prev;
    logic [15:0]        knob_low_volt;
    logic [15:0]        knob_mid_volt;
    logic [15:0]        knob_high_volt;
    logic [14:0]        mid_level_cm;
    logic [15:0]        slope_above;
    logic [15:0]        slope_below;
  } lpc_cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] adc_sample;
  } lpc_in_t;

  typedef struct packed {
    logic [7:0]  drive_byte;
    logic [3:0]  level_tens;
    logic [3:0]  level_ones;
    logic [15:0] setpoint_volts;
  } lpc_out_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic load_item;
    logic prep;
    logic mul_a;
    logic mul_b;
    logic commit;
    logic drive;
    logic load_out;
  } lpc_cmd_t;

  typedef struct packed {
    logic is_tick;
  } lpc_sts_t;

endpackage

FILE: sv/level_pi_controller_top.sv
// Liquid level regulator with an incremental PI law. Each input transfer is
// either an ADC event (action 0) or a control tick (action 1) and yields exactly
// one result transfer. ADC samples alternate between the setpoint knob (first
// after reset) and the level sensor: a knob sample sets the setpoint voltage by
// a two-segment map, a sensor sample sets the measured level in whole cm
// (0..99). A tick adds gain_prop*e + gain_prev*e_prev to a saturating
// integrator and drives the inverted byte of the output clamped to 0..5 V.
// Volts are unsigned Q3.13, gains signed Q15.8. One item is worked at a time:
// the sequencer steps one shared 25x21 multiplier through two products per
// item (prep, first product, second product, commit, drive on a tick only,
// then the output load), and the load waits while a held result is not taken.
// The result sits in an output register, so the next item can enter while it
// waits. Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i
// while the block is idle: a rule for the user, the block does not enforce it.
module level_pi_controller_top #(
  parameter int INTEGRATOR_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpc_pkg::lpc_in_t  in_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpc_pkg::lpc_out_t out_data_o,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [23:0]       cfg_wdata_i
);
  import lpc_pkg::*;

  lpc_cfg_t cfg;
  lpc_cmd_t cmd;
  lpc_sts_t sts;

  // gains, knob breakpoints and level curve
  lpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer: owns both handshakes and steps the datapath
  lpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, regulator state and result register
  lpc_datapath #(
    .INTEGRATOR_BITS (INTEGRATOR_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: sv/lpc_cfg_regs.sv
module lpc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [23:0]              cfg_wdata_i,
  output lpc_pkg::lpc_cfg_t        cfg_o
);
  import lpc_pkg::*;

  lpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAIN_PROP:      cfg_d.gain_prop      = cfg_wdata_i;
        CFG_GAIN_PREV:      cfg_d.gain_prev      = cfg_wdata_i;
        CFG_KNOB_LOW_VOLT:  cfg_d.knob_low_volt  = cfg_wdata_i[15:0];
        CFG_KNOB_MID_VOLT:  cfg_d.knob_mid_volt  = cfg_wdata_i[15:0];
        CFG_KNOB_HIGH_VOLT: cfg_d.knob_high_volt = cfg_wdata_i[15:0];
        CFG_MID_LEVEL_CM:   cfg_d.mid_level_cm   = cfg_wdata_i[14:0];
        CFG_SLOPE_ABOVE:    cfg_d.slope_above    = cfg_wdata_i[15:0];
        CFG_SLOPE_BELOW:    cfg_d.slope_below    = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop      <= RST_GAIN_PROP;
      cfg_q.gain_prev      <= RST_GAIN_PREV;
      cfg_q.knob_low_volt  <= RST_KNOB_LOW;
      cfg_q.knob_mid_volt  <= RST_KNOB_MID;
      cfg_q.knob_high_volt <= RST_KNOB_HIGH;
      cfg_q.mid_level_cm   <= RST_MID_CM;
      cfg_q.slope_above    <= RST_SLOPE_AB;
      cfg_q.slope_below    <= RST_SLOPE_BE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lpc_ctrl.sv
`include "level_pi_controller_top_macros.svh"

module lpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lpc_pkg::lpc_sts_t sts_i,
  output lpc_pkg::lpc_cmd_t cmd_o
);
  import lpc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_MULA   = 7'b0000100,
    ST_MULB   = 7'b0001000,
    ST_COMMIT = 7'b0010000,
    ST_DRIVE  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } lpc_state_e;

  lpc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;
  lpc_cmd_t   cmd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // result register can take a new value this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        cmd.load_item = accept;
        if (accept) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_d  = ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_a = 1'b1;
        state_d   = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b = 1'b1;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_d    = sts_i.is_tick ? ST_DRIVE : ST_OUT;
      end
      ST_DRIVE: begin
        cmd.drive = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `LPC_ASSERT(a_no_overwrite, cmd.load_out && out_valid_q |-> !out_stall_i, "result overwritten")
  `LPC_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o, "input open during work")
  `LPC_ASSERT_NEXT(a_valid_after_load, cmd.load_out, out_valid_o, "loaded result not shown")

endmodule

FILE: sv/lpc_datapath.sv
`include "level_pi_controller_top_macros.svh"

module lpc_datapath #(
  parameter int INTEGRATOR_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpc_pkg::lpc_in_t  in_data_i,
  input  lpc_pkg::lpc_cfg_t cfg_i,
  input  lpc_pkg::lpc_cmd_t cmd_i,
  output lpc_pkg::lpc_sts_t sts_o,
  output lpc_pkg::lpc_out_t out_data_o
);
  import lpc_pkg::*;

  localparam int IB    = INTEGRATOR_BITS;
  localparam int DW    = PROD_W + 1;
  localparam int SW    = ((IB > DW) ? IB : DW) + 1;
  localparam int XW    = ADC_BITS + VOLT_W;
  localparam int SUMW  = VOLT_W + 1;
  localparam int H2W   = SUMW - ADC_BITS;
  localparam int RW    = ADC_BITS + 2;
  localparam logic signed [IB-1:0] OUT_MAX_I = IB'(OUT_MAX);

  // item and working registers
  lpc_in_t                 item_q;
  logic [VOLT_W-1:0]       volt_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
  lpc_out_t                out_q;

  // controller state
  logic                    next_is_sensor_q;
  logic [VOLT_W-1:0]       setpoint_q, sensor_q;
  logic [6:0]              level_q;
  logic signed [IB-1:0]    integ_q;
  logic signed [ERR_W-1:0] prev_err_q;
  logic [7:0]              drive_q;

  logic is_tick, is_sensor;
  assign is_tick   = (item_q.action == ACT_TICK);
  assign is_sensor = !is_tick && next_is_sensor_q;
  assign sts_o.is_tick = is_tick;

  // sample to volts, division by 2^n-1 through two folds and one correction
  logic [XW-1:0]       volt_x;
  logic [VOLT_W-1:0]   volt_hi;
  logic [SUMW-1:0]     volt_s;
  logic [H2W-1:0]      volt_h2;
  logic [RW-1:0]       volt_r;
  logic [VOLT_W-1:0]   volt_calc;

  always_comb begin
    volt_x  = XW'(item_q.adc_sample) * XW'(FULL_SCALE);
    volt_hi = volt_x[XW-1:ADC_BITS];
    volt_s  = SUMW'(volt_hi) + SUMW'(volt_x[ADC_BITS-1:0]);
    volt_h2 = volt_s[SUMW-1:ADC_BITS];
    volt_r  = RW'(volt_h2) + RW'(volt_s[ADC_BITS-1:0]);
    volt_calc = volt_hi + VOLT_W'(volt_h2) + VOLT_W'(volt_r >= RW'(ADC_FULL));
  end

  // knob segment selection
  logic                    knob_upper;
  logic [VOLT_W-1:0]       knob_v, knob_base;
  logic signed [ERR_W-1:0] knob_diff;
  // sensor segment selection
  logic                    sens_above;
  logic [VOLT_W-1:0]       sens_slope;
  logic signed [ERR_W-1:0] sens_dv;

  always_comb begin
    knob_upper = (volt_q > VOLT_W'(HALF_SCALE));
    knob_v     = knob_upper ? (volt_q - VOLT_W'(HALF_SCALE)) : volt_q;
    knob_base  = knob_upper ? cfg_i.knob_mid_volt : cfg_i.knob_low_volt;
    knob_diff  = knob_upper ?
                 ($signed({1'b0, cfg_i.knob_high_volt}) - $signed({1'b0, cfg_i.knob_mid_volt})) :
                 ($signed({1'b0, cfg_i.knob_mid_volt}) - $signed({1'b0, cfg_i.knob_low_volt}));
    sens_above = (volt_q >= cfg_i.knob_mid_volt);
    sens_slope = sens_above ? cfg_i.slope_above : cfg_i.slope_below;
    sens_dv    = $signed({1'b0, volt_q}) - $signed({1'b0, cfg_i.knob_mid_volt});
  end

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]         knob_mag;
  logic [18:0]               knob_t;

  always_comb begin
    knob_mag = prod_a_q[PROD_W-1] ? (PROD_W'(0) - prod_a_q) : prod_a_q;
    knob_t   = knob_mag[30:12];
    if (cmd_i.mul_b) begin
      if (is_tick || is_sensor) begin
        mul_a = {cfg_i.gain_prev[GAIN_W-1], cfg_i.gain_prev};
        mul_b = {{(MUL_B_W-ERR_W){prev_err_q[ERR_W-1]}}, prev_err_q};
      end else begin
        mul_a = {{(MUL_A_W-19){1'b0}}, knob_t};
        mul_b = MUL_B_W'(RECIP5_WIDE);
      end
    end else begin
      if (is_tick) begin
        mul_a = {cfg_i.gain_prop[GAIN_W-1], cfg_i.gain_prop};
        mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end else if (is_sensor) begin
        mul_a = {{(MUL_A_W-VOLT_W){1'b0}}, sens_slope};
        mul_b = {{(MUL_B_W-ERR_W){sens_dv[ERR_W-1]}}, sens_dv};
      end else begin
        mul_a = {{(MUL_A_W-ERR_W){knob_diff[ERR_W-1]}}, knob_diff};
        mul_b = {{(MUL_B_W-VOLT_W){1'b0}}, knob_v};
      end
    end
    mul_p = mul_a * mul_b;
  end

  // knob: base plus quotient truncated toward zero
  logic [16:0]       knob_q5;
  logic [18:0]       knob_sp;
  // sensor: level in whole cm, clamped
  logic signed [DW-1:0] lvl_acc;
  logic [DW-22:0]    lvl_raw;
  logic [6:0]        lvl_cm;
  // tick: saturating integrator
  logic [DW-1:0]        pi_d;
  logic signed [SW-1:0] pi_sum, pi_max, pi_min;
  logic signed [IB-1:0] integ_next;

  always_comb begin
    knob_q5 = prod_b_q[38:22];
    knob_sp = prod_a_q[PROD_W-1] ? ({3'b000, knob_base} - {2'b00, knob_q5}) :
                                   ({3'b000, knob_base} + {2'b00, knob_q5});

    lvl_acc = $signed({prod_a_q[PROD_W-1], prod_a_q}) +
              $signed({{(DW-28){1'b0}}, cfg_i.mid_level_cm, 13'b0});
    lvl_raw = lvl_acc[DW-1:21];
    if (lvl_acc[DW-1])                      lvl_cm = 7'd0;
    else if (lvl_raw > (DW-21)'(LEVEL_MAX)) lvl_cm = 7'(LEVEL_MAX);
    else                                    lvl_cm = lvl_raw[6:0];

    pi_d   = {prod_a_q[PROD_W-1], prod_a_q} + {prod_b_q[PROD_W-1], prod_b_q};
    pi_sum = $signed({{(SW-IB){integ_q[IB-1]}}, integ_q}) +
             $signed({{(SW-DW){pi_d[DW-1]}}, pi_d});
    pi_max = $signed({{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}});
    pi_min = ~pi_max;
    if (pi_sum > pi_max)      integ_next = pi_max[IB-1:0];
    else if (pi_sum < pi_min) integ_next = pi_min[IB-1:0];
    else                      integ_next = pi_sum[IB-1:0];
  end

  // drive: clamp to 0..5 V, scale to a byte, invert
  logic [23:0] drv_o;
  logic [31:0] drv_y;
  logic [10:0] drv_t;
  logic [23:0] drv_ts;
  logic [7:0]  drv_byte;

  always_comb begin
    if (integ_q[IB-1])          drv_o = 24'(OUT_MAX);
    else if (integ_q > OUT_MAX_I) drv_o = 24'(OUT_MAX);
    else                        drv_o = integ_q[23:0];
    if (integ_q[IB-1]) drv_o = 24'd0;
    drv_y    = {drv_o, 8'b0} - {8'b0, drv_o};
    drv_t    = drv_y[31:21];
    drv_ts   = 24'(drv_t) * 24'(RECIP5_NARROW);
    drv_byte = ~drv_ts[22:15];
  end

  // level digits
  logic [13:0] dig_p;
  logic [3:0]  dig_tens;
  logic [3:0]  dig_ones;

  always_comb begin
    dig_p    = 14'(level_q) * 14'd103;
    dig_tens = dig_p[13:10];
    dig_ones = 4'(level_q - 7'(dig_tens) * 7'd10);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.prep) begin
      volt_q <= volt_calc;
      err_q  <= $signed({1'b0, setpoint_q}) - $signed({1'b0, sensor_q});
    end
    if (cmd_i.mul_a) prod_a_q <= mul_p;
    if (cmd_i.mul_b) prod_b_q <= mul_p;
    if (cmd_i.load_out) begin
      out_q.drive_byte     <= drive_q;
      out_q.level_tens     <= dig_tens;
      out_q.level_ones     <= dig_ones;
      out_q.setpoint_volts <= setpoint_q;
    end
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_is_sensor_q <= 1'b0;
      setpoint_q       <= '0;
      sensor_q         <= '0;
      level_q          <= '0;
      integ_q          <= '0;
      prev_err_q       <= '0;
      drive_q          <= '0;
    end else begin
      if (cmd_i.commit) begin
        if (is_tick) begin
          integ_q    <= integ_next;
          prev_err_q <= err_q;
        end else begin
          next_is_sensor_q <= !next_is_sensor_q;
          if (is_sensor) begin
            sensor_q <= volt_q;
            level_q  <= lvl_cm;
          end else begin
            setpoint_q <= knob_sp[15:0];
          end
        end
      end
      if (cmd_i.drive) drive_q <= drv_byte;
    end
  end

  assign out_data_o = out_q;

  `LPC_ASSERT_NEXT(a_tick_keeps_setpoint, cmd_i.commit && is_tick, $stable(setpoint_q), "tick moved setpoint")
  `LPC_ASSERT_NEXT(a_prev_err_update, cmd_i.commit && is_tick, prev_err_q == $past(err_q), "previous error not kept")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

package lpc_tb_pkg;
  import lpc_pkg::*;

  localparam int INTEG_BITS = 48;

  // tracks the regulator state and checks each result transfer in order
  class level_regulator_checker;
    lpc_cfg_t            cfg;
    bit                  sensor_next;
    logic [15:0]         setpoint;
    logic [15:0]         sensor;
    logic [6:0]          level_cm;
    longint              integ;      // kept at 48 bits by the saturation below
    logic signed [16:0]  prev_err;
    logic [7:0]          drive;
    lpc_out_t            awaited_outputs[$];
    int                  mismatch_count;
    int                  result_count;

    function new();
      cfg.gain_prop      = RST_GAIN_PROP;
      cfg.gain_prev      = RST_GAIN_PREV;
      cfg.knob_low_volt  = RST_KNOB_LOW;
      cfg.knob_mid_volt  = RST_KNOB_MID;
      cfg.knob_high_volt = RST_KNOB_HIGH;
      cfg.mid_level_cm   = RST_MID_CM;
      cfg.slope_above    = RST_SLOPE_AB;
      cfg.slope_below    = RST_SLOPE_BE;
      sensor_next    = 1'b0;
      setpoint       = '0;
      sensor         = '0;
      level_cm       = '0;
      integ          = 0;
      prev_err       = '0;
      drive          = '0;
      mismatch_count = 0;
      result_count   = 0;
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", result_count, msg);
      mismatch_count++;
    endtask

    function void set_reg(lpc_cfg_idx_e idx, logic [23:0] val);
      case (idx)
        CFG_GAIN_PROP:      cfg.gain_prop      = val;
        CFG_GAIN_PREV:      cfg.gain_prev      = val;
        CFG_KNOB_LOW_VOLT:  cfg.knob_low_volt  = val[15:0];
        CFG_KNOB_MID_VOLT:  cfg.knob_mid_volt  = val[15:0];
        CFG_KNOB_HIGH_VOLT: cfg.knob_high_volt = val[15:0];
        CFG_MID_LEVEL_CM:   cfg.mid_level_cm   = val[14:0];
        CFG_SLOPE_ABOVE:    cfg.slope_above    = val[15:0];
        CFG_SLOPE_BELOW:    cfg.slope_below    = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sat_add(longint acc, longint d);
      longint mx;
      longint mn;
      mx = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
      mn = -mx - 1;
      if (d > 0 && acc > mx - d) return mx;
      if (d < 0 && acc < mn - d) return mn;
      return acc + d;
    endfunction

    function lpc_out_t compute_outputs(lpc_in_t it);
      longint   v;
      longint   sp;
      longint   slope;
      longint   acc;
      longint   cm;
      longint   err;
      longint   d;
      longint   o;
      longint   q;
      longint   lo;
      longint   mid;
      longint   hi;
      lpc_out_t res;
      lo  = longint'(cfg.knob_low_volt);
      mid = longint'(cfg.knob_mid_volt);
      hi  = longint'(cfg.knob_high_volt);
      if (it.action == ACT_ADC) begin
        v = (longint'(it.adc_sample) * FULL_SCALE) / ADC_FULL;
        if (!sensor_next) begin
          // two-segment knob map, split at half scale
          if (v <= HALF_SCALE) sp = lo + (v * (mid - lo)) / HALF_SCALE;
          else sp = mid + ((v - HALF_SCALE) * (hi - mid)) / HALF_SCALE;
          setpoint = sp[15:0];
        end else begin
          slope = (v >= mid) ? longint'(cfg.slope_above) : longint'(cfg.slope_below);
          acc = (longint'(cfg.mid_level_cm) <<< 13) + slope * (v - mid);
          sensor = v[15:0];
          if (acc < 0) cm = 0;
          else begin
            cm = acc >>> 21;
            if (cm > LEVEL_MAX) cm = LEVEL_MAX;
          end
          level_cm = cm[6:0];
        end
        sensor_next = !sensor_next;
      end else begin
        err = longint'(setpoint) - longint'(sensor);
        d = longint'(cfg.gain_prop) * err + longint'(cfg.gain_prev) * longint'(prev_err);
        integ = sat_add(integ, d);
        o = integ;
        if (o > OUT_MAX) o = OUT_MAX;
        if (o < 0) o = 0;
        q = (o * 255) / OUT_MAX;
        drive = ~q[7:0];
        prev_err = err[16:0];
      end
      res.drive_byte     = drive;
      res.level_tens     = 4'(level_cm / 7'd10);
      res.level_ones     = 4'(level_cm % 7'd10);
      res.setpoint_volts = setpoint;
      return res;
    endfunction

    function void note_item(lpc_in_t it);
      awaited_outputs.push_back(compute_outputs(it));
    endfunction

    task check_result(lpc_out_t got);
      lpc_out_t want;
      result_count++;
      if (awaited_outputs.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        want = awaited_outputs.pop_front();
        if (got.drive_byte !== want.drive_byte)
          report($sformatf("drive_byte %0h, want %0h", got.drive_byte, want.drive_byte));
        if (got.level_tens !== want.level_tens)
          report($sformatf("level_tens %0d, want %0d", got.level_tens, want.level_tens));
        if (got.level_ones !== want.level_ones)
          report($sformatf("level_ones %0d, want %0d", got.level_ones, want.level_ones));
        if (got.setpoint_volts !== want.setpoint_volts)
          report($sformatf("setpoint_volts %0d, want %0d",
                           got.setpoint_volts, want.setpoint_volts));
      end
    endtask
  endclass

endpackage

module tb;
  import lpc_pkg::*;
  import lpc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  lpc_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  lpc_out_t    out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_wdata_i;

  level_regulator_checker sb;

  bit no_gaps;        // sender stretch with back-to-back transfers
  bit hold_request;   // asks the receiver for one long hold-off
  int quiet_cycles;
  int stall_left;
  bit stall_val;

  level_pi_controller_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // transfer monitor and watchdog, sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) begin
        sb.note_item(in_data_i);
        quiet_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("** level_pi_controller_top: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stall runs, mostly short, sometimes long, plus one
  // requested hold-off that lets the block back up into its input
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    stall_val   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_val    = 1'b1;
          stall_left   = HOLD_CYCLES;
        end else begin
          case ($urandom_range(0, 99) / 5)
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
              stall_val  = 1'b0;
              stall_left = $urandom_range(1, 20);
            end
            18: begin
              stall_val  = 1'b1;
              stall_left = $urandom_range(8, 40);
            end
            default: begin
              stall_val  = 1'b1;
              stall_left = $urandom_range(1, 3);
            end
          endcase
        end
      end
      out_stall_i <= stall_val;
      stall_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic lpc_in_t make_item(logic act, logic [7:0] smp);
    lpc_in_t it;
    it.action     = act;
    it.adc_sample = smp;
    return it;
  endfunction

  // offer one item; returns at the edge where it is taken
  task automatic send_item(lpc_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic adc(logic [7:0] smp);
    send_item(make_item(ACT_ADC, smp));
  endtask

  task automatic tick();
    send_item(make_item(ACT_TICK, 8'($urandom)));
  endtask

  // random mix, with edge samples weighted up and stretches without gaps
  task automatic run_random(int n);
    logic [7:0] smp;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       smp = 8'h00;
        1:       smp = 8'hff;
        default: smp = 8'($urandom);
      endcase
      if ($urandom_range(0, 99) < 40) send_item(make_item(ACT_TICK, smp));
      else send_item(make_item(ACT_ADC, smp));
    end
    no_gaps = 1'b0;
  endtask

  task automatic run_ticks(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      tick();
    end
    no_gaps = 1'b0;
  endtask

  // drop valid and let every outstanding result arrive before touching config
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(lpc_cfg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // junk_hi puts random bits above the width of the narrower registers
  task automatic load_config(lpc_cfg_t c, bit junk_hi);
    logic [8:0] hi;
    hi = junk_hi ? 9'($urandom) : 9'd0;
    write_reg(CFG_GAIN_PROP,      c.gain_prop);
    write_reg(CFG_GAIN_PREV,      c.gain_prev);
    write_reg(CFG_KNOB_LOW_VOLT,  {hi[7:0], c.knob_low_volt});
    write_reg(CFG_KNOB_MID_VOLT,  {hi[8:1], c.knob_mid_volt});
    write_reg(CFG_KNOB_HIGH_VOLT, {hi[7:0], c.knob_high_volt});
    write_reg(CFG_MID_LEVEL_CM,   {hi, c.mid_level_cm});
    write_reg(CFG_SLOPE_ABOVE,    {hi[8:1], c.slope_above});
    write_reg(CFG_SLOPE_BELOW,    {hi[7:0], c.slope_below});
  endtask

  function automatic lpc_cfg_t rand_config();
    lpc_cfg_t c;
    c.gain_prop      = 24'($urandom);
    c.gain_prev      = 24'($urandom);
    c.knob_low_volt  = 16'($urandom_range(0, FULL_SCALE));
    c.knob_mid_volt  = 16'($urandom_range(0, FULL_SCALE));
    c.knob_high_volt = 16'($urandom_range(0, FULL_SCALE));
    c.mid_level_cm   = 15'($urandom_range(0, 25600));
    c.slope_above    = 16'($urandom);
    c.slope_below    = 16'($urandom);
    return c;
  endfunction

  // knob next so that a full-scale setpoint meets an empty sensor
  task automatic max_error_pair();
    if (sb.sensor_next) adc(8'h00);
    adc(8'hff);
    adc(8'h00);
  endtask

  lpc_cfg_t c;

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_GAIN_PROP;
    cfg_wdata_i  = '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration: tick before any sample, both knob
    // segments around half scale, sensor on both sides of the breakpoint,
    // drive pushed up to the 5 V clamp and back down to 0 V
    tick();
    adc(8'h00);
    adc(8'h00);
    tick();
    adc(8'hff);
    adc(8'hff);
    tick();
    tick();
    adc(8'd128);
    adc(8'd22);
    adc(8'd127);
    adc(8'd21);
    tick();
    adc(8'haa);
    adc(8'h55);
    repeat (4) tick();
    adc(8'h00);
    adc(8'hff);
    repeat (3) tick();
    drain();

    // random in-range settings, junk above the narrow fields, and one long
    // receiver hold-off with the sender still pushing
    load_config(rand_config(), 1'b1);
    run_random(30);
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    for (int i = 0; i < 8; i++) adc(8'($urandom));
    no_gaps = 1'b0;
    run_random(25);
    drain();

    // every register at zero; breakpoint sits at 0 V
    load_config('0, 1'b0);
    run_random(20);
    drain();

    // largest gains and full-width knob values: integrator runs into its
    // upper limit
    c.gain_prop      = 24'h7fffff;
    c.gain_prev      = 24'h7fffff;
    c.knob_low_volt  = 16'd0;
    c.knob_mid_volt  = 16'hffff;
    c.knob_high_volt = 16'hffff;
    c.mid_level_cm   = 15'h7fff;
    c.slope_above    = 16'hffff;
    c.slope_below    = 16'hffff;
    load_config(c, 1'b0);
    max_error_pair();
    run_ticks(140);
    drain();

    // most negative gains: same error now drags it down to the lower limit
    c.gain_prop = 24'h800000;
    c.gain_prev = 24'h800000;
    load_config(c, 1'b0);
    run_ticks(270);
    drain();

    // reversed knob map, breakpoint at 0 V and steep slopes so the level
    // clamps at 99 cm
    c = rand_config();
    c.knob_low_volt  = 16'(FULL_SCALE);
    c.knob_mid_volt  = 16'd0;
    c.knob_high_volt = 16'd0;
    c.mid_level_cm   = 15'h7fff;
    c.slope_above    = 16'hffff;
    c.slope_below    = 16'hffff;
    load_config(c, 1'b0);
    run_random(30);
    drain();

    load_config(rand_config(), 1'b0);
    run_random(25);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.awaited_outputs.size() == 0) begin
      $display("** level_pi_controller_top: PASSED **");
    end else begin
      $display("** level_pi_controller_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lpc_pkg.sv
sv/lpc_cfg_regs.sv
sv/lpc_ctrl.sv
sv/lpc_datapath.sv
sv/level_pi_controller_top.sv
tb/tb.sv
